// ===== src/wstfr_pkg.sv =====
// Shared types and constants for the WebSocket text frame receiver.
// No dependencies; imported by websocket_text_frame_receiver.
package wstfr_pkg;

	typedef enum logic [1:0] {
		EV_BYTE  = 2'd0,
		EV_DONE  = 2'd1,
		EV_CLOSE = 2'd2,
		EV_ERROR = 2'd3
	} event_kind_t;

	localparam logic [3:0] OPC_TEXT  = 4'h1;
	localparam logic [3:0] OPC_CLOSE = 4'h8;
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       conn_lost;
	} rx_req_t;

	typedef struct packed {
		event_kind_t event_kind;
		logic [7:0]  out_byte;
		logic [6:0]  frame_length;
		logic        last_byte;
	} ev_req_t;

endpackage

// ===== src/websocket_text_frame_receiver.sv =====
// WebSocket text frame receiver: one received byte in, at most one event out.
// Accepts one byte per cycle; an input register feeds the header/mask/payload
// parser, whose event lands in an output register. A stalled output register
// holds the parser, and the input register then stalls the byte side.
// Depends on wstfr_pkg.
module websocket_text_frame_receiver
	import wstfr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    rx_valid,
	output logic    rx_stall,
	input  rx_req_t rx_req,
	output logic    ev_valid,
	input  logic    ev_stall,
	output ev_req_t ev_req
);

	typedef enum logic [1:0] {
		PH_HDR0 = 2'd0,
		PH_HDR1 = 2'd1,
		PH_MASK = 2'd2,
		PH_DATA = 2'd3
	} phase_t;

	logic        valid_s1;
	rx_req_t     req_s1;
	logic        adv;

	phase_t      phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [6:0]  len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [6:0]  cnt_q, cnt_d;
	logic        emit;
	ev_req_t     ev_d;

	logic [6:0]  cnt_inc;
	logic [7:0]  key_byte;
	logic [6:0]  hdr_len;

	assign adv      = valid_s1 && (!ev_valid || !ev_stall);
	assign rx_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			req_s1 <= rx_req;
		end
	end

	assign cnt_inc  = cnt_q + 7'd1;
	assign key_byte = key_q[{cnt_q[1:0], 3'b000} +: 8];
	assign hdr_len  = req_s1.rx_byte[6:0];

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		masked_d = masked_q;
		len_d    = len_q;
		key_d    = key_q;
		cnt_d    = cnt_q;
		emit     = 1'b0;
		ev_d     = '{event_kind: EV_BYTE, out_byte: 8'd0, frame_length: 7'd0,
			last_byte: 1'b0};
		if (req_s1.conn_lost) begin
			phase_d         = PH_HDR0;
			emit            = 1'b1;
			ev_d.event_kind = EV_ERROR;
		end else begin
			unique case (phase_q)
				PH_HDR0: begin
					opcode_d = req_s1.rx_byte[3:0];
					phase_d  = PH_HDR1;
				end
				PH_HDR1: begin
					masked_d = req_s1.rx_byte[7];
					len_d    = hdr_len;
					cnt_d    = 7'd0;
					key_d    = 32'd0;
					phase_d  = PH_HDR0;
					priority if (opcode_q == OPC_CLOSE) begin
						emit            = 1'b1;
						ev_d.event_kind = EV_CLOSE;
					end else if (opcode_q != OPC_TEXT ||
						hdr_len == LEN_EXT16 || hdr_len == LEN_EXT64) begin
						emit            = 1'b1;
						ev_d.event_kind = EV_ERROR;
					end else if (req_s1.rx_byte[7]) begin
						phase_d = PH_MASK;
					end else if (hdr_len == 7'd0) begin
						emit            = 1'b1;
						ev_d.event_kind = EV_DONE;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_MASK: begin
					key_d[{cnt_q[1:0], 3'b000} +: 8] = req_s1.rx_byte;
					cnt_d = cnt_inc;
					if (cnt_q[1:0] == 2'd3) begin
						cnt_d = 7'd0;
						if (len_q == 7'd0) begin
							phase_d         = PH_HDR0;
							emit            = 1'b1;
							ev_d.event_kind = EV_DONE;
						end else begin
							phase_d = PH_DATA;
						end
					end
				end
				PH_DATA: begin
					emit            = 1'b1;
					ev_d.event_kind = EV_BYTE;
					ev_d.out_byte   = masked_q ? (req_s1.rx_byte ^ key_byte)
						: req_s1.rx_byte;
					cnt_d = cnt_inc;
					if (cnt_inc >= len_q) begin
						phase_d           = PH_HDR0;
						cnt_d             = 7'd0;
						ev_d.frame_length = len_q;
						ev_d.last_byte    = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= 4'd0;
			masked_q <= 1'b0;
			len_q    <= 7'd0;
			key_q    <= 32'd0;
			cnt_q    <= 7'd0;
			ev_valid <= 1'b0;
		end else begin
			if (adv) begin
				phase_q  <= phase_d;
				opcode_q <= opcode_d;
				masked_q <= masked_d;
				len_q    <= len_d;
				key_q    <= key_d;
				cnt_q    <= cnt_d;
				ev_valid <= emit;
			end else if (ev_valid && !ev_stall) begin
				ev_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			ev_req <= ev_d;
		end
	end

	a_last_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_req.last_byte |-> ev_req.event_kind == EV_BYTE &&
		ev_req.frame_length != 7'd0)
		else $error("last_byte on a non-payload event");

	a_ctrl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_req.event_kind != EV_BYTE |->
		ev_req.out_byte == 8'd0 && ev_req.frame_length == 7'd0)
		else $error("control event carries payload fields");

	a_mask_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MASK |-> cnt_q < 7'd4)
		else $error("mask byte count out of range");

	a_data_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> cnt_q < len_q)
		else $error("payload count passed frame length");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && ev_stall |=> ev_valid && $stable(phase_q))
		else $error("parser advanced under output stall");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for websocket_text_frame_receiver: directed header, mask and payload cases,
// then random frame streams under sender idling and receiver stalls.
// Depends on wstfr_pkg and the receiver RTL; checks every event against its own parser.
module testbench;
	import wstfr_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef enum logic [1:0] {
		WAIT_HDR0,
		WAIT_HDR1,
		GET_KEY,
		GET_DATA
	} parse_phase_t;

	logic    clk;
	logic    arst_n = 1'b0;
	logic    rx_valid = 1'b0;
	logic    rx_stall;
	rx_req_t rx_req = '0;
	logic    ev_valid;
	logic    ev_stall = 1'b0;
	ev_req_t ev_req;

	int rx_idle_pct = 0;
	int ev_stall_pct = 0;
	int fail_count = 0;
	int quiet_cycles = 0;

	ev_req_t pending_events[$];
	ev_req_t want;

	parse_phase_t prs_phase = WAIT_HDR0;
	logic [3:0]   prs_opcode = '0;
	logic         prs_masked = 1'b0;
	logic [6:0]   prs_len = '0;
	logic [31:0]  prs_key = '0;
	logic [6:0]   prs_count = '0;

	websocket_text_frame_receiver i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_valid),
		.rx_stall (rx_stall),
		.rx_req   (rx_req),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev_req   (ev_req)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(negedge clk) begin
		ev_stall <= ($urandom_range(99) < ev_stall_pct);
	end

	// Advance the parser by one accepted request and queue the event it gives.
	task automatic parse_rx_byte(input rx_req_t req);
		ev_req_t ev;
		logic    gives;
		logic [7:0] b;
		logic [7:0] v;
		ev.event_kind = EV_BYTE;
		ev.out_byte = '0;
		ev.frame_length = '0;
		ev.last_byte = 1'b0;
		gives = 1'b0;
		b = req.rx_byte;
		if (req.conn_lost) begin
			prs_phase = WAIT_HDR0;
			ev.event_kind = EV_ERROR;
			gives = 1'b1;
		end else begin
			case (prs_phase)
				WAIT_HDR0: begin
					prs_opcode = b[3:0];
					prs_phase = WAIT_HDR1;
				end
				WAIT_HDR1: begin
					prs_masked = b[7];
					prs_len = b[6:0];
					prs_count = '0;
					prs_key = '0;
					prs_phase = WAIT_HDR0;
					if (prs_opcode == OPC_CLOSE) begin
						ev.event_kind = EV_CLOSE;
						gives = 1'b1;
					end else if (prs_opcode != OPC_TEXT || prs_len == LEN_EXT16
							|| prs_len == LEN_EXT64) begin
						ev.event_kind = EV_ERROR;
						gives = 1'b1;
					end else if (prs_masked) begin
						prs_phase = GET_KEY;
					end else if (prs_len == 0) begin
						ev.event_kind = EV_DONE;
						gives = 1'b1;
					end else begin
						prs_phase = GET_DATA;
					end
				end
				GET_KEY: begin
					prs_key = prs_key | (32'(b) << (8 * prs_count[1:0]));
					prs_count = prs_count + 7'd1;
					if (prs_count >= 7'd4) begin
						prs_count = '0;
						if (prs_len == 0) begin
							prs_phase = WAIT_HDR0;
							ev.event_kind = EV_DONE;
							gives = 1'b1;
						end else begin
							prs_phase = GET_DATA;
						end
					end
				end
				default: begin
					v = b;
					if (prs_masked)
						v = v ^ prs_key[8 * prs_count[1:0] +: 8];
					prs_count = prs_count + 7'd1;
					ev.out_byte = v;
					gives = 1'b1;
					if (prs_count >= prs_len) begin
						prs_phase = WAIT_HDR0;
						prs_count = '0;
						ev.frame_length = prs_len;
						ev.last_byte = 1'b1;
					end
				end
			endcase
		end
		if (gives)
			pending_events.push_back(ev);
	endtask

	// Entered and left just after a falling edge; valid stays high on return.
	task automatic send_rx(input rx_req_t req);
		while ($urandom_range(99) < rx_idle_pct) begin
			rx_valid <= 1'b0;
			rx_req <= rx_req_t'($urandom);
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_req <= req;
		do
			@(posedge clk);
		while (rx_stall);
		parse_rx_byte(req);
		@(negedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_rx(rx_req_t'({b, 1'b0}));
	endtask

	task automatic send_lost();
		logic [7:0] junk;
		junk = 8'($urandom);
		send_rx(rx_req_t'({junk, 1'b1}));
	endtask

	task automatic test_close_and_rejects();
		send_byte(8'h88);
		send_byte(8'h80);
		send_byte(8'h70);
		send_byte(8'h05);
		send_byte(8'h81);
		send_byte(8'h7E);
		send_byte(8'h01);
		send_byte(8'hFF);
	endtask

	task automatic test_empty_frames();
		send_byte(8'h81);
		send_byte(8'h00);
		send_byte(8'h81);
		send_byte(8'h80);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'hA5);
	endtask

	task automatic test_masked_frame();
		send_byte(8'hF1);
		send_byte(8'h85);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h04);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h7F);
	endtask

	task automatic test_conn_lost();
		send_byte(8'h81);
		send_byte(8'h03);
		send_byte(8'h41);
		send_lost();
	endtask

	// Mostly well-formed frames with random content; some cut short by a lost link.
	task automatic send_random_frame(inout int sent);
		logic [7:0] hdr0;
		logic [7:0] hdr1;
		int sel;
		int len;
		int total;
		int cut_at;
		hdr0 = 8'($urandom);
		sel = $urandom_range(99);
		if (sel < 80)
			hdr0[3:0] = OPC_TEXT;
		else if (sel < 88)
			hdr0[3:0] = OPC_CLOSE;
		sel = $urandom_range(99);
		if (sel < 3)
			len = 125;
		else if (sel < 8)
			len = $urandom_range(124, 13);
		else if (sel < 12)
			len = $urandom_range(127, 126);
		else
			len = $urandom_range(12, 0);
		hdr1[7] = 1'($urandom_range(1));
		hdr1[6:0] = len[6:0];
		total = 2;
		if (hdr0[3:0] == OPC_TEXT && len < 126)
			total += (hdr1[7] ? 4 : 0) + len;
		cut_at = ($urandom_range(99) < 10) ? $urandom_range(total - 1, 0) : total;
		for (int i = 0; i < total; i++) begin
			sent++;
			if (i == cut_at) begin
				send_lost();
				break;
			end
			if (i == 0)
				send_byte(hdr0);
			else if (i == 1)
				send_byte(hdr1);
			else
				send_byte(8'($urandom));
		end
	endtask

	task automatic test_random_stream(input int rx_pct, input int ev_pct, input int n);
		int sent;
		sent = 0;
		rx_idle_pct = rx_pct;
		ev_stall_pct = ev_pct;
		while (sent < n) begin
			if ($urandom_range(99) < 8) begin
				sent++;
				if ($urandom_range(3) == 0)
					send_lost();
				else
					send_byte(8'($urandom));
			end else begin
				send_random_frame(sent);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (ev_valid && !ev_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL");
				$finish;
			end
			if (ev_valid && !ev_stall) begin
				if (pending_events.size() == 0) begin
					$error("event with none pending: event_kind %0d out_byte %0h",
						ev_req.event_kind, ev_req.out_byte);
					fail_count++;
				end else begin
					want = pending_events.pop_front();
					if (ev_req.event_kind !== want.event_kind) begin
						$error("event_kind: expected %0d, got %0d",
							want.event_kind, ev_req.event_kind);
						fail_count++;
					end
					if (ev_req.out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h",
							want.out_byte, ev_req.out_byte);
						fail_count++;
					end
					if (ev_req.frame_length !== want.frame_length) begin
						$error("frame_length: expected %0d, got %0d",
							want.frame_length, ev_req.frame_length);
						fail_count++;
					end
					if (ev_req.last_byte !== want.last_byte) begin
						$error("last_byte: expected %0b, got %0b",
							want.last_byte, ev_req.last_byte);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_close_and_rejects();
		test_empty_frames();
		test_masked_frame();
		test_conn_lost();
		test_random_stream(0, 0, 440);
		test_random_stream(83, 0, 440);
		test_random_stream(0, 83, 440);
		test_random_stream(7, 7, 440);
		rx_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/wstfr_pkg.sv
src/websocket_text_frame_receiver.sv
sim/testbench.sv
